// File: sv/htbd_pkg.sv
// Package: types, constants and defaults for the Huffman tree bit decoder.
`timescale 1ns / 1ps
`default_nettype none
package htbd_pkg;
    localparam int NODE_COUNT_DEF  = 512;
    localparam int STACK_DEPTH_DEF = 32;
    localparam int TOKEN_BYTES_DEF = 2;
    localparam logic [7:0] ESCAPE_RESET = 8'd7;

    typedef enum logic [1:0] {
        OP_BEGIN = 2'd0,
        OP_TREE  = 2'd1,
        OP_DATA  = 2'd2,
        OP_END   = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PLACE,
        ST_FIX,
        ST_BIT,
        ST_READ,
        ST_EVAL,
        ST_EMIT,
        ST_NEXT,
        ST_FLUSH
    } state_t;
endpackage
`default_nettype wire

// File: sv/huffman_tree_bit_decoder_core.sv
// Top level: Huffman tree loader and bit-serial tree-walk decoder.
// Begin, end and non-final tree byte items are taken in idle. The final byte of a
// token goes on to ST_PLACE, and to ST_FIX when it completes a pending right child.
// An encoded byte is walked bit by bit; a tree step reads the cursor node, then the
// child (one read port). ST_EMIT and ST_FLUSH (last byte) may wait on out_ready.
// Reset (rst_n low, async) empties the tree, cursor and literal state, escape = 7.
`timescale 1ns / 1ps
`default_nettype none
module huffman_tree_bit_decoder_core #(
    parameter int NODE_COUNT  = htbd_pkg::NODE_COUNT_DEF,
    parameter int STACK_DEPTH = htbd_pkg::STACK_DEPTH_DEF,
    parameter int TOKEN_BYTES = htbd_pkg::TOKEN_BYTES_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] operation,
    input  wire logic [7:0] value,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            last,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_data
);
    localparam int NW  = $clog2(NODE_COUNT);
    localparam int FW  = $clog2(NODE_COUNT + 1);
    localparam int SW  = $clog2(STACK_DEPTH);
    localparam int TW  = $clog2(STACK_DEPTH + 1);
    localparam int TB  = 8 * TOKEN_BYTES;
    localparam int PW  = $clog2(TOKEN_BYTES + 1);
    localparam int LW  = $clog2(TB + 1);
    localparam int EW  = (TOKEN_BYTES > 1) ? $clog2(TOKEN_BYTES) : 1;
    localparam int RW  = NW + 1;
    localparam int ENW = 1 + TB;

    // node entry: {leaf, token bytes}; right child kept apart (0 = none)
    logic [ENW-1:0] node_mem [NODE_COUNT];
    logic [RW-1:0]  right_mem [NODE_COUNT];
    logic [NW-1:0]  stack_mem [STACK_DEPTH];

    htbd_pkg::state_t state_reg, state_next;
    logic [7:0]    esc_reg;
    logic [FW-1:0] fill_reg, fill_next;
    logic [TW-1:0] top_reg, top_next;
    logic [PW-1:0] phase_reg, phase_next;
    logic [TB-1:0] tok_reg, tok_next;
    logic          open_reg, open_next;
    logic [NW-1:0] cur_reg, cur_next;
    logic [LW-1:0] lit_left_reg, lit_left_next;
    logic [TB-1:0] lit_reg, lit_next;
    logic [7:0]    byte_reg, byte_next;
    logic [2:0]    bit_reg, bit_next;
    logic [NW-1:0] child_reg, child_next;
    logic [TB-1:0] emit_reg, emit_next;
    logic [EW-1:0] ecnt_reg, ecnt_next;
    logic [7:0]    hold_reg, hold_next;
    logic          hv_reg, hv_next;
    logic          ov_reg, ov_next;
    logic [7:0]    ob_reg, ob_next;
    logic          ol_reg, ol_next;

    logic [ENW-1:0] rd_reg;
    logic [RW-1:0]  rr_reg;
    logic [NW-1:0]  rd_addr;
    logic [NW-1:0]  pop_reg;
    logic           node_we;
    logic           right_we;
    logic [NW-1:0]  right_wa;
    logic [RW-1:0]  right_wd;
    logic           st_we;
    logic           inner;
    logic           bitv;
    logic           rd_leaf;
    logic [TB-1:0]  rd_tok;
    logic [RW-1:0]  cand;

    assign in_ready  = (state_reg == htbd_pkg::ST_IDLE);
    assign cfg_ready = (state_reg == htbd_pkg::ST_IDLE);
    assign out_valid = ov_reg;
    assign out_byte  = ob_reg;
    assign last      = ol_reg;
    assign rd_leaf   = rd_reg[ENW-1];
    assign rd_tok    = rd_reg[TB-1:0];
    assign inner     = (tok_reg[TB-1 -: 8] == 8'd0);
    assign bitv      = byte_reg[3'(3'd7 - bit_reg)];

    always_ff @(posedge clk)
    begin
        if (node_we)
            node_mem[fill_reg[NW-1:0]] <= {!inner, tok_reg};
        if (right_we)
            right_mem[right_wa] <= right_wd;
        if (st_we)
            stack_mem[top_reg[SW-1:0]] <= fill_reg[NW-1:0];
        rd_reg  <= node_mem[rd_addr];
        rr_reg  <= right_mem[rd_addr];
        pop_reg <= stack_mem[SW'(top_reg - TW'(1))];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= htbd_pkg::ST_IDLE;
            esc_reg <= htbd_pkg::ESCAPE_RESET;
            fill_reg <= '0; top_reg <= '0; phase_reg <= '0; tok_reg <= '0;
            open_reg <= 1'b1; cur_reg <= '0; lit_left_reg <= '0; lit_reg <= '0;
            ov_reg <= 1'b0; hv_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                esc_reg <= cfg_data;
            fill_reg <= fill_next; top_reg <= top_next; phase_reg <= phase_next;
            tok_reg <= tok_next; open_reg <= open_next; cur_reg <= cur_next;
            lit_left_reg <= lit_left_next; lit_reg <= lit_next;
            ov_reg <= ov_next; hv_reg <= hv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next; bit_reg <= bit_next; child_reg <= child_next;
        emit_reg <= emit_next; ecnt_reg <= ecnt_next; hold_reg <= hold_next;
        ob_reg <= ob_next; ol_reg <= ol_next;
    end

    always_comb
    begin
        state_next = state_reg;
        fill_next = fill_reg; top_next = top_reg; phase_next = phase_reg;
        tok_next = tok_reg; open_next = open_reg; cur_next = cur_reg;
        lit_left_next = lit_left_reg; lit_next = lit_reg;
        byte_next = byte_reg; bit_next = bit_reg; child_next = child_reg;
        emit_next = emit_reg; ecnt_next = ecnt_reg;
        hold_next = hold_reg; hv_next = hv_reg;
        ov_next = ov_reg; ob_next = ob_reg; ol_next = ol_reg;
        rd_addr = cur_reg; node_we = 1'b0; right_we = 1'b0;
        right_wa = fill_reg[NW-1:0]; right_wd = '0; st_we = 1'b0;
        cand = '0;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        unique case (state_reg)
            htbd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (htbd_pkg::op_t'(operation))
                        htbd_pkg::OP_BEGIN:
                        begin
                            fill_next = '0; top_next = '0; phase_next = '0;
                            tok_next = '0; open_next = 1'b1; cur_next = '0;
                            lit_left_next = '0; lit_next = '0;
                        end
                        htbd_pkg::OP_TREE:
                        begin
                            if (open_reg)
                            begin
                                tok_next[TB-1 - 8*phase_reg -: 8] = value;
                                if (phase_reg == PW'(TOKEN_BYTES - 1))
                                begin
                                    phase_next = '0;
                                    state_next = htbd_pkg::ST_PLACE;
                                end
                                else
                                    phase_next = phase_reg + PW'(1);
                            end
                        end
                        htbd_pkg::OP_DATA:
                        begin
                            byte_next = value;
                            bit_next = '0;
                            state_next = htbd_pkg::ST_BIT;
                        end
                        htbd_pkg::OP_END:
                        begin
                            cur_next = '0; lit_left_next = '0; lit_next = '0;
                        end
                    endcase
                end
            end
            htbd_pkg::ST_PLACE:
            begin
                state_next = htbd_pkg::ST_IDLE;
                if (fill_reg >= FW'(NODE_COUNT) || (inner && top_reg >= TW'(STACK_DEPTH)))
                    open_next = 1'b0;
                else
                begin
                    node_we = 1'b1;
                    right_we = 1'b1;
                    fill_next = fill_reg + FW'(1);
                    if (inner)
                    begin
                        st_we = 1'b1;
                        top_next = top_reg + TW'(1);
                    end
                    else if (top_reg == '0)
                        open_next = 1'b0;
                    else
                    begin
                        top_next = top_reg - TW'(1);
                        state_next = htbd_pkg::ST_FIX;
                    end
                end
            end
            htbd_pkg::ST_FIX:
            begin
                // popped inner node gets the node after this leaf as right child
                right_we = 1'b1;
                right_wa = pop_reg;
                right_wd = RW'(fill_reg);
                state_next = htbd_pkg::ST_IDLE;
            end
            htbd_pkg::ST_BIT:
            begin
                if (lit_left_reg != '0)
                begin
                    lit_next = {lit_reg[TB-2:0], bitv};
                    lit_left_next = lit_left_reg - LW'(1);
                    state_next = htbd_pkg::ST_NEXT;
                    if (lit_left_reg == LW'(1))
                    begin
                        emit_next = {lit_reg[TB-2:0], bitv}; ecnt_next = '0;
                        lit_next = '0; cur_next = '0;
                        state_next = htbd_pkg::ST_EMIT;
                    end
                end
                else if (fill_reg == '0)
                    state_next = htbd_pkg::ST_NEXT;
                else
                begin
                    if (FW'(cur_reg) >= fill_reg)
                    begin
                        cur_next = '0;
                        rd_addr = '0;
                    end
                    state_next = htbd_pkg::ST_READ;
                end
            end
            htbd_pkg::ST_READ:
            begin
                // cursor node in rd_reg / rr_reg
                if (rd_leaf)
                begin
                    child_next = cur_reg;
                    state_next = htbd_pkg::ST_EVAL;
                end
                else
                begin
                    cand = bitv ? rr_reg : RW'(cur_reg) + RW'(1);
                    if (cand == '0 || cand >= RW'(fill_reg))
                    begin
                        cur_next = '0;
                        state_next = htbd_pkg::ST_NEXT;
                    end
                    else
                    begin
                        rd_addr = NW'(cand);
                        child_next = NW'(cand);
                        state_next = htbd_pkg::ST_EVAL;
                    end
                end
            end
            htbd_pkg::ST_EVAL:
            begin
                // child node in rd_reg
                state_next = htbd_pkg::ST_NEXT;
                if (!rd_leaf)
                    cur_next = child_reg;
                else
                begin
                    cur_next = '0;
                    if (rd_tok[TB-1 -: 8] == esc_reg)
                    begin
                        lit_left_next = LW'(TB);
                        lit_next = '0;
                    end
                    else
                    begin
                        emit_next = rd_tok;
                        ecnt_next = '0;
                        state_next = htbd_pkg::ST_EMIT;
                    end
                end
            end
            htbd_pkg::ST_EMIT:
            begin
                // newest byte waits in hold until it is known whether it is the last
                if (!hv_reg || !ov_reg || out_ready)
                begin
                    if (hv_reg)
                    begin
                        ov_next = 1'b1;
                        ob_next = hold_reg;
                        ol_next = 1'b0;
                    end
                    hold_next = emit_reg[TB-1 - 8*ecnt_reg -: 8];
                    hv_next = 1'b1;
                    if (ecnt_reg == EW'(TOKEN_BYTES - 1))
                        state_next = htbd_pkg::ST_NEXT;
                    else
                        ecnt_next = ecnt_reg + EW'(1);
                end
            end
            htbd_pkg::ST_NEXT:
            begin
                if (bit_reg == 3'd7)
                    state_next = hv_reg ? htbd_pkg::ST_FLUSH : htbd_pkg::ST_IDLE;
                else
                begin
                    bit_next = bit_reg + 3'd1;
                    state_next = htbd_pkg::ST_BIT;
                end
            end
            htbd_pkg::ST_FLUSH:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next = 1'b1;
                    ob_next = hold_reg;
                    ol_next = 1'b1;
                    hv_next = 1'b0;
                    state_next = htbd_pkg::ST_IDLE;
                end
            end
            default:
                state_next = htbd_pkg::ST_IDLE;
        endcase
    end

    initial_check: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !out_ready) |=> (ov_reg && $stable(ob_reg) && $stable(ol_reg)))
        else $error("result dropped while stalled");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == htbd_pkg::ST_IDLE))
        else $error("ready outside idle");
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(NODE_COUNT))
        else $error("node fill overflow");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == htbd_pkg::ST_IDLE) |-> !hv_reg)
        else $error("held byte left at idle");
endmodule
`default_nettype wire
